FILE: hw/rtl/stack_light_sequencer_defines.svh
// Assertion macros used by the stack light sequencer top level.
`ifndef STACK_LIGHT_SEQUENCER_DEFINES_SVH
`define STACK_LIGHT_SEQUENCER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SLSEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define SLSEQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/slseq_pkg.sv
// Types, constants and table functions of the stack light sequencer.
package slseq_pkg;

  localparam int TIMER_BITS  = 16;
  localparam int TEST_PHASES = 22;
  localparam int PHASE_W     = $clog2(TEST_PHASES + 1);
  localparam int CMP_W       = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam int OUT_W       = 12;
  localparam int OUT_DATA_W  = ((OUT_W + 7) / 8) * 8;
  localparam int IN_W        = 5;
  localparam int IN_DATA_W   = ((IN_W + 7) / 8) * 8;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ACTIVE_LOW = 3'd0,
    REG_SLOW_FLASH = 3'd1,
    REG_FAST_FLASH = 3'd2,
    REG_BOOT_ALL_ON = 3'd3,
    REG_BOOT_STEP  = 3'd4
  } reg_e;

  localparam logic        RST_ACTIVE_LOW  = 1'b1;
  localparam logic [15:0] RST_SLOW_FLASH  = 16'd500;
  localparam logic [15:0] RST_FAST_FLASH  = 16'd150;
  localparam logic [15:0] RST_BOOT_ALL_ON = 16'd1000;
  localparam logic [15:0] RST_BOOT_STEP   = 16'd500;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_SET_STATE  = 3'd1,
    ACT_SELF_TEST  = 3'd2,
    ACT_ALL_ON     = 3'd3,
    ACT_FORCE_OFF  = 3'd4,
    ACT_COLOR_TEST = 3'd5,
    ACT_BOOT_START = 3'd6,
    ACT_BOOT_STOP  = 3'd7
  } act_e;

  typedef enum logic [2:0] {
    PAT_OFF   = 3'd0,
    PAT_SOLID = 3'd1,
    PAT_SLOW  = 3'd2,
    PAT_FAST  = 3'd3,
    PAT_ALT   = 3'd4
  } pat_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_BOOT   = 2'd1,
    MODE_TEST   = 2'd2,
    MODE_ALL_ON = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CH_OFF = 2'd0,
    CH_ON  = 2'd1,
    CH_FL  = 2'd2
  } ch_e;

  localparam logic [1:0] COL_NONE   = 2'd0;
  localparam logic [1:0] COL_RED    = 2'd1;
  localparam logic [1:0] COL_YELLOW = 2'd2;
  localparam logic [1:0] COL_GREEN  = 2'd3;

  // Relay drive bits: bit 0 red, bit 1 yellow, bit 2 green.
  localparam logic [2:0] DRV_OFF    = 3'b000;
  localparam logic [2:0] DRV_RED    = 3'b001;
  localparam logic [2:0] DRV_YELLOW = 3'b010;
  localparam logic [2:0] DRV_GREEN  = 3'b100;
  localparam logic [2:0] DRV_ALL    = 3'b111;

  typedef struct packed {
    logic ctest;
    logic forced;
    logic allon;
    logic test;
    logic boot;
  } mode_flags_t;

  typedef struct packed {
    logic       ctest;
    logic       forced;
    pat_e       pattern;
    logic [1:0] color;
  } saved_t;

  typedef struct packed {
    logic [1:0]            color;
    pat_e                  pattern;
    mode_flags_t           flags;
    logic                  flash_on;
    logic [TIMER_BITS-1:0] flash_el;
    logic [PHASE_W-1:0]    phase;
    logic [TIMER_BITS-1:0] phase_el;
    logic                  boot_cyc;
    logic [1:0]            boot_step;
    logic [TIMER_BITS-1:0] boot_el;
    saved_t                saved;
    logic [2:0]            drive;
  } seq_state_t;

  typedef struct packed {
    act_e       action;
    logic [2:0] pattern;
    logic [1:0] color;
  } item_t;

  // Result word, lowest field in the lowest bits.
  typedef struct packed {
    logic [2:0] pattern;
    logic [1:0] color;
    logic       ctest;
    logic       forced;
    mode_e      mode;
    logic       green;
    logic       yellow;
    logic       red;
  } result_t;

  typedef struct packed {
    ch_e green;
    ch_e yellow;
    ch_e red;
  } test_row_t;

  // Sequencer state after reset: everything clear except the flash phase.
  function automatic seq_state_t reset_state();
    seq_state_t s;
    s          = '0;
    s.flash_on = 1'b1;
    return s;
  endfunction

  function automatic logic [2:0] one_hot(input logic [1:0] color);
    logic [2:0] d;
    case (color)
      COL_RED:    d = DRV_RED;
      COL_YELLOW: d = DRV_YELLOW;
      COL_GREEN:  d = DRV_GREEN;
      default:    d = DRV_OFF;
    endcase
    return d;
  endfunction

  function automatic pat_e clean_pattern(input logic [2:0] p);
    pat_e r;
    case (p)
      PAT_SOLID: r = PAT_SOLID;
      PAT_SLOW:  r = PAT_SLOW;
      PAT_FAST:  r = PAT_FAST;
      PAT_ALT:   r = PAT_ALT;
      default:   r = PAT_OFF;
    endcase
    return r;
  endfunction

  function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] v);
    return (v == {TIMER_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic due(input logic [TIMER_BITS-1:0] el, input logic [15:0] period);
    return CMP_W'(el) >= CMP_W'(period);
  endfunction

  // Self-test lamp table; odd phases and phases past the table are dark.
  function automatic test_row_t test_row(input logic [PHASE_W-1:0] phase);
    test_row_t r;
    case (phase)
      PHASE_W'(0):  r = '{green: CH_ON,  yellow: CH_ON,  red: CH_ON};
      PHASE_W'(2):  r = '{green: CH_OFF, yellow: CH_OFF, red: CH_ON};
      PHASE_W'(4):  r = '{green: CH_OFF, yellow: CH_ON,  red: CH_OFF};
      PHASE_W'(6):  r = '{green: CH_ON,  yellow: CH_OFF, red: CH_OFF};
      PHASE_W'(8):  r = '{green: CH_OFF, yellow: CH_OFF, red: CH_FL};
      PHASE_W'(10): r = '{green: CH_OFF, yellow: CH_FL,  red: CH_OFF};
      PHASE_W'(12): r = '{green: CH_FL,  yellow: CH_OFF, red: CH_OFF};
      PHASE_W'(14): r = '{green: CH_OFF, yellow: CH_FL,  red: CH_ON};
      PHASE_W'(16): r = '{green: CH_OFF, yellow: CH_ON,  red: CH_FL};
      PHASE_W'(18): r = '{green: CH_FL,  yellow: CH_FL,  red: CH_OFF};
      PHASE_W'(20): r = '{green: CH_FL,  yellow: CH_FL,  red: CH_FL};
      default:      r = '{green: CH_OFF, yellow: CH_OFF, red: CH_OFF};
    endcase
    return r;
  endfunction

  function automatic logic [15:0] test_len(input logic [PHASE_W-1:0] phase);
    logic [15:0] n;
    case (phase)
      PHASE_W'(0):  n = 16'd1000;
      PHASE_W'(2),
      PHASE_W'(4),
      PHASE_W'(6):  n = 16'd700;
      PHASE_W'(8),
      PHASE_W'(10),
      PHASE_W'(12),
      PHASE_W'(14),
      PHASE_W'(16),
      PHASE_W'(18),
      PHASE_W'(20): n = 16'd2000;
      default:      n = 16'd300;
    endcase
    return n;
  endfunction

  function automatic logic lamp(input ch_e ch, input logic flash_on);
    return (ch == CH_ON) || ((ch == CH_FL) && flash_on);
  endfunction

  function automatic logic [2:0] test_drive(input test_row_t r, input logic flash_on);
    return {lamp(r.green, flash_on), lamp(r.yellow, flash_on), lamp(r.red, flash_on)};
  endfunction

  function automatic mode_e mode_of(input mode_flags_t f);
    mode_e m;
    if (f.boot) begin
      m = MODE_BOOT;
    end else if (f.test) begin
      m = MODE_TEST;
    end else if (f.allon) begin
      m = MODE_ALL_ON;
    end else begin
      m = MODE_NORMAL;
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/stack_light_sequencer.sv
// Top level of the stack light sequencer: relay pattern and test sequencer.
//
//  Channel   | Direction | Handshake                   | Payload
//  ----------+-----------+-----------------------------+--------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser: action; tdata: color, pattern
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: levels, mode, flags, signal
//  cfg       | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One item is taken in every cycle while the output is not stalled. An accepted
// transfer is held in the input register, where the state update and the result
// are computed in a single pass; the result is then captured in the result
// register, which drives output valid. Reset clears the valid flags and the
// sequencer state (the flash phase starts on) and loads the configuration reset
// values; the item and result data registers are not reset, but no clearing
// pass is needed. A stalled output holds the result register and the input
// register, and input ready drops only while both are full.
module stack_light_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [1:0] color, [4:2] pattern, [7:5] zero
  input  logic [slseq_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: [2:0] action
  input  logic [2:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [0] red_level, [1] yellow_level, [2] green_level, [4:3] active_mode,
  //        [5] forced_off_flag, [6] color_test_flag, [8:7] current_color,
  //        [11:9] current_pattern, [15:12] zero
  output logic [slseq_pkg::OUT_DATA_W-1:0] m_axis_tdata,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers. Writes must arrive only while the block is idle;
  // the block itself does not enforce this. The port is always ready.
  logic        active_low_q;
  logic [15:0] slow_flash_q;
  logic [15:0] fast_flash_q;
  logic [15:0] boot_all_on_q;
  logic [15:0] boot_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q  <= slseq_pkg::RST_ACTIVE_LOW;
      slow_flash_q  <= slseq_pkg::RST_SLOW_FLASH;
      fast_flash_q  <= slseq_pkg::RST_FAST_FLASH;
      boot_all_on_q <= slseq_pkg::RST_BOOT_ALL_ON;
      boot_step_q   <= slseq_pkg::RST_BOOT_STEP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (slseq_pkg::reg_e'(cfg_index_i))
        slseq_pkg::REG_ACTIVE_LOW:  active_low_q  <= cfg_data_i[0];
        slseq_pkg::REG_SLOW_FLASH:  slow_flash_q  <= cfg_data_i;
        slseq_pkg::REG_FAST_FLASH:  fast_flash_q  <= cfg_data_i;
        slseq_pkg::REG_BOOT_ALL_ON: boot_all_on_q <= cfg_data_i;
        slseq_pkg::REG_BOOT_STEP:   boot_step_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register and output register handshake. The input stage moves on
  // whenever the result register is empty or being drained in this cycle.
  logic              in_vld_q;
  slseq_pkg::item_t  item_q;
  logic              out_vld_q;
  slseq_pkg::result_t res_q;
  slseq_pkg::result_t res_d;
  logic              advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = slseq_pkg::OUT_DATA_W'(res_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.action  <= slseq_pkg::act_e'(s_axis_tuser);
      item_q.color   <= s_axis_tdata[1:0];
      item_q.pattern <= s_axis_tdata[4:2];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Sequencer state. Every field is architectural, so all of it is reset.
  slseq_pkg::seq_state_t st_q;
  slseq_pkg::seq_state_t st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= slseq_pkg::reset_state();
    end else begin
      st_q <= st_d;
    end
  end

  // Single-pass update: the item in the input register moves the state on by
  // one step, and the result is taken from the updated state.
  always_comb begin
    st_d = st_q;
    if (advance) begin
      case (item_q.action)
        slseq_pkg::ACT_TICK: begin
          // All three elapsed counters run on every tick, whatever the mode.
          st_d.flash_el = slseq_pkg::bump(st_q.flash_el);
          st_d.phase_el = slseq_pkg::bump(st_q.phase_el);
          st_d.boot_el  = slseq_pkg::bump(st_q.boot_el);
          if (st_q.flags.boot) begin
            if (!st_q.boot_cyc && !slseq_pkg::due(st_d.boot_el, boot_all_on_q)) begin
              st_d.drive = slseq_pkg::DRV_ALL;
            end else begin
              if (!st_q.boot_cyc) begin
                // All-on phase is over: start the color cycle at red.
                st_d.boot_cyc  = 1'b1;
                st_d.boot_step = 2'd0;
                st_d.boot_el   = '0;
              end
              if (slseq_pkg::due(st_d.boot_el, boot_step_q)) begin
                st_d.boot_step = (st_d.boot_step >= 2'd2) ? 2'd0 : st_d.boot_step + 2'd1;
                st_d.boot_el   = '0;
              end
              st_d.drive = slseq_pkg::DRV_RED << st_d.boot_step;
            end
          end else if (st_q.flags.test) begin
            if (slseq_pkg::due(st_d.phase_el, slseq_pkg::test_len(st_q.phase))) begin
              st_d.phase    = st_q.phase + 1'b1;
              st_d.phase_el = '0;
            end
            if (st_d.phase >= slseq_pkg::PHASE_W'(slseq_pkg::TEST_PHASES)) begin
              // End of the table: bring back the signal held before the test.
              st_d.flags        = '0;
              st_d.color        = st_q.saved.color;
              st_d.pattern      = st_q.saved.pattern;
              st_d.flags.forced = st_q.saved.forced;
              st_d.flags.ctest  = st_q.saved.ctest;
              st_d.flash_on     = 1'b1;
              st_d.flash_el     = '0;
              st_d.drive        = slseq_pkg::one_hot(st_q.saved.color);
            end else begin
              if (slseq_pkg::due(st_d.flash_el, slow_flash_q)) begin
                st_d.flash_on = !st_q.flash_on;
                st_d.flash_el = '0;
              end
              st_d.drive = slseq_pkg::test_drive(slseq_pkg::test_row(st_d.phase),
                                                 st_d.flash_on);
            end
          end else if (st_q.flags.allon) begin
            st_d.drive = slseq_pkg::DRV_ALL;
          end else begin
            case (st_q.pattern)
              slseq_pkg::PAT_SOLID: begin
                st_d.drive = slseq_pkg::one_hot(st_q.color);
              end
              slseq_pkg::PAT_SLOW: begin
                // The slow and fast flashing patterns only touch the relays when the phase flips.
                if (slseq_pkg::due(st_d.flash_el, slow_flash_q)) begin
                  st_d.flash_on = !st_q.flash_on;
                  st_d.flash_el = '0;
                  st_d.drive    = st_d.flash_on ? slseq_pkg::one_hot(st_q.color)
                                                : slseq_pkg::DRV_OFF;
                end
              end
              slseq_pkg::PAT_FAST: begin
                if (slseq_pkg::due(st_d.flash_el, fast_flash_q)) begin
                  st_d.flash_on = !st_q.flash_on;
                  st_d.flash_el = '0;
                  st_d.drive    = st_d.flash_on ? slseq_pkg::one_hot(st_q.color)
                                                : slseq_pkg::DRV_OFF;
                end
              end
              slseq_pkg::PAT_ALT: begin
                // Alternating ignores the stored color: red, then yellow.
                if (slseq_pkg::due(st_d.flash_el, fast_flash_q)) begin
                  st_d.flash_on = !st_q.flash_on;
                  st_d.flash_el = '0;
                end
                st_d.drive = st_d.flash_on ? slseq_pkg::DRV_RED : slseq_pkg::DRV_YELLOW;
              end
              default: begin
                st_d.drive = slseq_pkg::DRV_OFF;
              end
            endcase
          end
        end
        slseq_pkg::ACT_SET_STATE: begin
          // The color lights at once; the pattern takes over on the next tick.
          st_d.flags    = '0;
          st_d.color    = item_q.color;
          st_d.pattern  = slseq_pkg::clean_pattern(item_q.pattern);
          st_d.flash_on = 1'b1;
          st_d.flash_el = '0;
          st_d.drive    = slseq_pkg::one_hot(item_q.color);
        end
        slseq_pkg::ACT_SELF_TEST: begin
          // A restart during a running test keeps the state saved first.
          if (!st_q.flags.test) begin
            st_d.saved.color   = st_q.color;
            st_d.saved.pattern = st_q.pattern;
            st_d.saved.forced  = st_q.flags.forced;
            st_d.saved.ctest   = st_q.flags.ctest;
          end
          st_d.flags      = '0;
          st_d.flags.test = 1'b1;
          st_d.phase      = '0;
          st_d.phase_el   = '0;
          st_d.flash_on   = 1'b1;
          st_d.flash_el   = '0;
        end
        slseq_pkg::ACT_ALL_ON: begin
          st_d.flags       = '0;
          st_d.flags.allon = 1'b1;
          st_d.drive       = slseq_pkg::DRV_ALL;
        end
        slseq_pkg::ACT_FORCE_OFF: begin
          st_d.flags        = '0;
          st_d.flags.forced = 1'b1;
          st_d.color        = slseq_pkg::COL_NONE;
          st_d.pattern      = slseq_pkg::PAT_OFF;
          st_d.flash_on     = 1'b1;
          st_d.flash_el     = '0;
          st_d.drive        = slseq_pkg::DRV_OFF;
        end
        slseq_pkg::ACT_COLOR_TEST: begin
          st_d.flags       = '0;
          st_d.flags.ctest = 1'b1;
          st_d.color       = item_q.color;
          st_d.pattern     = slseq_pkg::PAT_SOLID;
          st_d.flash_on    = 1'b1;
          st_d.flash_el    = '0;
          st_d.drive       = slseq_pkg::one_hot(item_q.color);
        end
        slseq_pkg::ACT_BOOT_START: begin
          st_d.flags      = '0;
          st_d.flags.boot = 1'b1;
          st_d.boot_cyc   = 1'b0;
          st_d.boot_step  = 2'd0;
          st_d.boot_el    = '0;
          st_d.drive      = slseq_pkg::DRV_ALL;
        end
        slseq_pkg::ACT_BOOT_STOP: begin
          st_d.flags.boot = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Result fields come from the updated state; polarity is applied here.
  always_comb begin
    res_d.red     = st_d.drive[0] ^ active_low_q;
    res_d.yellow  = st_d.drive[1] ^ active_low_q;
    res_d.green   = st_d.drive[2] ^ active_low_q;
    res_d.mode    = slseq_pkg::mode_of(st_d.flags);
    res_d.forced  = st_d.flags.forced;
    res_d.ctest   = st_d.flags.ctest;
    res_d.color   = st_d.color;
    res_d.pattern = st_d.pattern;
  end

  `include "stack_light_sequencer_defines.svh"

  `SLSEQ_ASSERT(a_flags_exclusive, $onehot0(st_q.flags), "more than one mode flag is set")
  `SLSEQ_ASSERT(a_result_follows, advance |=> out_vld_q, "processed item produced no result")
  `SLSEQ_ASSERT(a_stall_holds_item, (in_vld_q && out_vld_q && !m_axis_tready) |=> in_vld_q, "item dropped while output stalled")
  `SLSEQ_ASSERT_NEVER(a_boot_step_range, st_q.boot_step == 2'd3, "boot step left the color cycle")
  `SLSEQ_ASSERT(a_test_phase_range, st_q.flags.test |-> (st_q.phase < slseq_pkg::PHASE_W'(slseq_pkg::TEST_PHASES)), "self test ran past its last phase")

endmodule

FILE: tb/stack_light_checker.sv
// Checker for the stack light sequencer: predicts every result word and compares it.
module stack_light_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [slseq_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic [2:0]                       s_tuser_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [slseq_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [2:0]                       cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  output int                               errors_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import slseq_pkg::*;

  // Configuration copy.
  logic        lamp_inv;
  logic [15:0] slow_ms, fast_ms, boot_on_ms, boot_step_ms;

  // Tower state.
  logic [1:0]  sig_col;
  pat_e        sig_pat;
  mode_flags_t flags;
  logic        flash_on;
  logic [15:0] flash_cnt, phase_cnt, boot_cnt;
  int unsigned test_idx;
  logic        boot_cyc;
  logic [1:0]  boot_idx;
  saved_t      saved;
  logic [2:0]  drive;

  result_t tower_expected[$];

  function automatic logic [2:0] lamp_of(input logic [1:0] col);
    return (col == COL_NONE) ? DRV_OFF : 3'(3'b001 << (col - 2'd1));
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Self-test phase lengths: phases 8 to 20 are longest, odd phases are dark gaps.
  function automatic logic [15:0] test_phase_ticks(input int unsigned ph);
    logic [15:0] n;
    if (ph == 0) begin
      n = 16'd1000;
    end else if ((ph % 2) == 1 || ph >= 22) begin
      n = 16'd300;
    end else if (ph <= 6) begin
      n = 16'd700;
    end else begin
      n = 16'd2000;
    end
    return n;
  endfunction

  function automatic logic [2:0] test_phase_lamps(input int unsigned ph, input logic fl);
    logic [2:0] on_m;
    logic [2:0] fl_m;
    on_m = DRV_OFF;
    fl_m = DRV_OFF;
    case (ph)
      0:  on_m = DRV_ALL;
      2:  on_m = DRV_RED;
      4:  on_m = DRV_YELLOW;
      6:  on_m = DRV_GREEN;
      8:  fl_m = DRV_RED;
      10: fl_m = DRV_YELLOW;
      12: fl_m = DRV_GREEN;
      14: begin
        on_m = DRV_RED;
        fl_m = DRV_YELLOW;
      end
      16: begin
        on_m = DRV_YELLOW;
        fl_m = DRV_RED;
      end
      18: fl_m = DRV_YELLOW | DRV_GREEN;
      20: fl_m = DRV_ALL;
      default: ;
    endcase
    return on_m | (fl ? fl_m : DRV_OFF);
  endfunction

  task automatic reset_tower();
    lamp_inv     = 1'b1;
    slow_ms      = 16'd500;
    fast_ms      = 16'd150;
    boot_on_ms   = 16'd1000;
    boot_step_ms = 16'd500;
    sig_col      = COL_NONE;
    sig_pat      = PAT_OFF;
    flags        = '0;
    flash_on     = 1'b1;
    flash_cnt    = '0;
    phase_cnt    = '0;
    boot_cnt     = '0;
    test_idx     = 0;
    boot_cyc     = 1'b0;
    boot_idx     = '0;
    saved        = '0;
    drive        = DRV_OFF;
  endtask

  task automatic load_signal(input logic [1:0] col, input logic [2:0] pat);
    flags     = '0;
    sig_col   = col;
    sig_pat   = (pat <= 3'd4) ? pat_e'(pat) : PAT_OFF;
    flash_on  = 1'b1;
    flash_cnt = '0;
    drive     = lamp_of(col);
  endtask

  task automatic flash_step(input logic [15:0] period, output logic toggled);
    toggled = 1'b0;
    if (flash_cnt >= period) begin
      flash_on  = ~flash_on;
      flash_cnt = '0;
      toggled   = 1'b1;
    end
  endtask

  task automatic tower_tick();
    logic toggled;
    flash_cnt = sat_inc(flash_cnt);
    phase_cnt = sat_inc(phase_cnt);
    boot_cnt  = sat_inc(boot_cnt);
    if (flags.boot) begin
      if (!boot_cyc) begin
        if (boot_cnt < boot_on_ms) begin
          drive = DRV_ALL;
        end else begin
          boot_cyc = 1'b1;
          boot_idx = '0;
          boot_cnt = '0;
        end
      end
      if (boot_cyc) begin
        if (boot_cnt >= boot_step_ms) begin
          boot_idx = (boot_idx >= 2'd2) ? 2'd0 : boot_idx + 2'd1;
          boot_cnt = '0;
        end
        drive = 3'(3'b001 << boot_idx);
      end
    end else if (flags.test) begin
      if (phase_cnt >= test_phase_ticks(test_idx)) begin
        test_idx++;
        phase_cnt = '0;
      end
      if (test_idx >= TEST_PHASES) begin
        // End of the table: the signal from before the test comes back.
        load_signal(saved.color, saved.pattern);
        flags.forced = saved.forced;
        flags.ctest  = saved.ctest;
      end else begin
        flash_step(slow_ms, toggled);
        drive = test_phase_lamps(test_idx, flash_on);
      end
    end else if (flags.allon) begin
      drive = DRV_ALL;
    end else begin
      case (sig_pat)
        PAT_SOLID: drive = lamp_of(sig_col);
        PAT_SLOW: begin
          flash_step(slow_ms, toggled);
          if (toggled) drive = flash_on ? lamp_of(sig_col) : DRV_OFF;
        end
        PAT_FAST: begin
          flash_step(fast_ms, toggled);
          if (toggled) drive = flash_on ? lamp_of(sig_col) : DRV_OFF;
        end
        PAT_ALT: begin
          flash_step(fast_ms, toggled);
          drive = flash_on ? DRV_RED : DRV_YELLOW;
        end
        default: drive = DRV_OFF;
      endcase
    end
  endtask

  task automatic step_tower(input logic [2:0] act_code, input logic [1:0] col,
                            input logic [2:0] pat, output result_t res);
    act_e act;
    act = act_e'(act_code);
    case (act)
      ACT_TICK:      tower_tick();
      ACT_SET_STATE: load_signal(col, pat);
      ACT_SELF_TEST: begin
        // A restart keeps the state saved by the first start.
        if (!flags.test) begin
          saved.color   = sig_col;
          saved.pattern = sig_pat;
          saved.forced  = flags.forced;
          saved.ctest   = flags.ctest;
        end
        flags      = '0;
        flags.test = 1'b1;
        test_idx   = 0;
        phase_cnt  = '0;
        flash_on   = 1'b1;
        flash_cnt  = '0;
      end
      ACT_ALL_ON: begin
        flags       = '0;
        flags.allon = 1'b1;
        drive       = DRV_ALL;
      end
      ACT_FORCE_OFF: begin
        load_signal(COL_NONE, PAT_OFF);
        flags.forced = 1'b1;
      end
      ACT_COLOR_TEST: begin
        load_signal(col, PAT_SOLID);
        flags.ctest = 1'b1;
      end
      ACT_BOOT_START: begin
        flags      = '0;
        flags.boot = 1'b1;
        boot_cyc   = 1'b0;
        boot_idx   = '0;
        boot_cnt   = '0;
        drive      = DRV_ALL;
      end
      default: flags.boot = 1'b0;
    endcase

    res        = '0;
    res.red    = drive[0] ^ lamp_inv;
    res.yellow = drive[1] ^ lamp_inv;
    res.green  = drive[2] ^ lamp_inv;
    if (flags.boot) begin
      res.mode = MODE_BOOT;
    end else if (flags.test) begin
      res.mode = MODE_TEST;
    end else if (flags.allon) begin
      res.mode = MODE_ALL_ON;
    end else begin
      res.mode = MODE_NORMAL;
    end
    res.forced  = flags.forced;
    res.ctest   = flags.ctest;
    res.color   = sig_col;
    res.pattern = sig_pat;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] word, input result_t want);
    result_t got;
    got = word[OUT_W-1:0];
    if (got.red !== want.red)         report_mismatch("red level", got.red, want.red);
    if (got.yellow !== want.yellow)   report_mismatch("yellow level", got.yellow, want.yellow);
    if (got.green !== want.green)     report_mismatch("green level", got.green, want.green);
    if (got.mode !== want.mode)       report_mismatch("active mode", got.mode, want.mode);
    if (got.forced !== want.forced)   report_mismatch("forced off flag", got.forced, want.forced);
    if (got.ctest !== want.ctest)     report_mismatch("color test flag", got.ctest, want.ctest);
    if (got.color !== want.color)     report_mismatch("current color", got.color, want.color);
    if (got.pattern !== want.pattern) report_mismatch("current pattern", got.pattern, want.pattern);
    if (word[OUT_DATA_W-1:OUT_W] !== '0) report_mismatch("padding", word[OUT_DATA_W-1:OUT_W], 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      reset_tower();
      tower_expected.delete();
      pending_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (tower_expected.size() == 0) begin
          report_mismatch("result word with nothing awaited", m_tdata_i, 0);
        end else begin
          want = tower_expected.pop_front();
          check_result(m_tdata_i, want);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ACTIVE_LOW:  lamp_inv     = cfg_data_i[0];
          REG_SLOW_FLASH:  slow_ms      = cfg_data_i;
          REG_FAST_FLASH:  fast_ms      = cfg_data_i;
          REG_BOOT_ALL_ON: boot_on_ms   = cfg_data_i;
          REG_BOOT_STEP:   boot_step_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        step_tower(s_tuser_i, s_tdata_i[1:0], s_tdata_i[4:2], want);
        tower_expected.push_back(want);
      end
      pending_o = tower_expected.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the stack light sequencer testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slseq_pkg::*;

  // Pattern code above the defined range; the block must treat it as off.
  localparam logic [2:0] PAT_CODE_SEVEN = 3'd7;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [2:0]            s_axis_tuser  = ACT_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_index_i   = REG_ACTIVE_LOW;
  logic [15:0]           cfg_data_i    = '0;

  int tower_errors;
  int tower_pending;

  // When set, neither side inserts gaps.
  bit no_gaps     = 1'b0;
  // A one-shot request for the receiver to hold off for a long stretch.
  bit hold_output = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stack_light_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  stack_light_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (tower_errors),
    .pending_o   (tower_pending)
  );

  // Offers one item after a random gap and returns at the edge of its transfer.
  // The valid line is only lowered when a gap follows, so back-to-back items
  // keep it high without a glitch.
  task automatic send_item(input act_e act, input logic [1:0] col, input logic [2:0] pat);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(IN_DATA_W - 5){1'b0}}, pat, col};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Most random items are ticks so that the flash and boot timers advance;
  // the rest are commands over every code, including the undefined patterns.
  task automatic send_random();
    act_e        act;
    logic [2:0]  pat;
    act = ($urandom_range(0, 99) < 60) ? ACT_TICK : act_e'($urandom_range(1, 7));
    pat = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    send_item(act, 2'($urandom_range(0, 3)), pat);
  endtask

  // Stops offering and waits until every expected result word has arrived.
  // Every item yields exactly one result, so the block is idle afterwards.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tower_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Raises the write channel for one register; the caller lowers it at the end
  // of a series so that consecutive writes keep valid high.
  task automatic put_reg(input reg_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_timing(input logic inv, input logic [15:0] slow, input logic [15:0] fast,
                             input logic [15:0] all_on, input logic [15:0] step);
    put_reg(REG_ACTIVE_LOW, {15'd0, inv});
    put_reg(REG_SLOW_FLASH, slow);
    put_reg(REG_FAST_FLASH, fast);
    put_reg(REG_BOOT_ALL_ON, all_on);
    put_reg(REG_BOOT_STEP, step);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random items with occasional stretches free of gaps. With with_hold set,
  // the receiver is asked for a long hold-off while items keep coming, and
  // later the sender pauses until the pipeline is empty.
  task automatic random_burst(input int count, input bit with_hold);
    for (int k = 0; k < count; k++) begin
      if ((k % 32) == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (with_hold && k == 40) hold_output = 1'b1;
      if (with_hold && k == 90) settle();
      send_random();
    end
    no_gaps = 1'b0;
  endtask

  // Receiver: a random wait before each result transfer, and one long
  // hold-off on request, counted here in cycles, that fills the block.
  initial begin
    int unsigned w;
    @(posedge rst_ni);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      w = no_gaps ? 0 : $urandom_range(0, 11);
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset configuration: every command at least once, the
    // undefined pattern code, a self-test restart and boot stop while idle.
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_SET_STATE, COL_RED, PAT_SOLID);
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_SET_STATE, COL_GREEN, PAT_CODE_SEVEN);
    send_item(ACT_TICK, COL_GREEN, PAT_CODE_SEVEN);
    send_item(ACT_SET_STATE, COL_YELLOW, PAT_SLOW);
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_COLOR_TEST, COL_GREEN, PAT_FAST);
    send_item(ACT_SELF_TEST, COL_RED, PAT_ALT);
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_SELF_TEST, COL_YELLOW, PAT_SOLID);
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_ALL_ON, COL_NONE, PAT_OFF);
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_FORCE_OFF, COL_GREEN, PAT_SOLID);
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_BOOT_START, COL_NONE, PAT_OFF);
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_BOOT_STOP, COL_NONE, PAT_OFF);
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_SET_STATE, COL_NONE, PAT_ALT);
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_SET_STATE, COL_YELLOW, PAT_FAST);
    send_item(ACT_TICK, COL_NONE, PAT_OFF);
    send_item(ACT_BOOT_STOP, COL_RED, PAT_SLOW);
    settle();

    // Short timings so flashing and the boot cycle show within a few ticks.
    // The third setting puts zero in the flash and boot step registers, so
    // every tick is a toggle or a step there.
    load_timing(1'b0, 16'd3, 16'd1, 16'd0, 16'd1);
    random_burst(130, 1'b0);
    settle();
    load_timing(1'b1, 16'd2, 16'd3, 16'd5, 16'd3);
    random_burst(130, 1'b1);
    settle();
    load_timing(1'b0, 16'd0, 16'd0, 16'd1, 16'd0);
    random_burst(140, 1'b0);
    settle();

    repeat (10) @(posedge clk_i);
    if (tower_errors == 0 && tower_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a fifth of this.
  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: stack_light_sequencer.f
+incdir+hw/rtl
hw/rtl/slseq_pkg.sv
hw/rtl/stack_light_sequencer.sv
tb/stack_light_checker.sv
tb/testbench.sv
